// File: src/catmull_rom_spline_evaluator_defines.svh
// Assertion macros for the spline evaluator port checker.
// Depends on clk and rst_n being visible where a macro is used.
`ifndef CATMULL_ROM_SPLINE_EVALUATOR_DEFINES_SVH
`define CATMULL_ROM_SPLINE_EVALUATOR_DEFINES_SVH

// Same-cycle implication, off while in reset
`define CRSE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off while in reset
`define CRSE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that also covers the reset cycle
`define CRSE_ASSERT_NXT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/crse_pkg.sv
// Types and constants for the Catmull-Rom spline evaluator.
// No dependencies; used by crse_mul, the evaluator top level and both checkers.
package crse_pkg;

  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 32;
  localparam int T_W       = FRAC_BITS + 1;
  localparam int MUL_A_W   = 34;
  localparam int MUL_B_W   = 20;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int ACC_W     = PROD_W + 3;

  localparam logic [T_W-1:0] T_ONE = T_W'(1) << FRAC_BITS;

  // request actions
  localparam logic [1:0] ACT_WRITE   = 2'd0;
  localparam logic [1:0] ACT_GLOBAL  = 2'd1;
  localparam logic [1:0] ACT_SEGMENT = 2'd2;
  localparam logic [1:0] ACT_NONE    = 2'd3;

  // result status codes
  localparam logic [1:0] ST_EVAL  = 2'd0;
  localparam logic [1:0] ST_WRITE = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_POS, S_POS_W, S_CHECK, S_PICK, S_PICK_W, S_READ,
    S_T2, S_T2_W, S_T3, S_T3_W, S_WGT, S_MUL, S_ACC, S_FIN
  } crse_state_t;

  typedef struct packed {
    logic signed [MUL_A_W-1:0] a;
    logic signed [MUL_B_W-1:0] b;
  } crse_mul_req_t;

endpackage

// File: src/crse_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module crse_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

// File: src/crse_mul.sv
// Shared signed multiplier with a registered product.
// Depends on crse_pkg for operand widths and the request struct.
module crse_mul
  import crse_pkg::*;
(
  input  logic                     clk,
  input  crse_mul_req_t            req,
  output logic signed [PROD_W-1:0] prod_r
);

  // register every product
  always_ff @(posedge clk) begin
    prod_r <= req.a * req.b;
  end

endmodule

// File: src/catmull_rom_spline_evaluator.sv
// Catmull-Rom spline evaluator: writes and evaluations that land on a control
// point need no curve math, while the time of full curve evaluations is set by
// the one shared multiplier (t^2 and t^3, then four weighted terms for each of
// the three axes, with a multiply and an accumulate step each) and the single
// read port of the point store (6 reads). After reset a clearing pass zeroes the
// store, one point per cycle, and no request is taken meanwhile.
// Depends on crse_pkg, crse_ram and crse_mul.
module catmull_rom_spline_evaluator
  import crse_pkg::*;
#(
  parameter int MAX_POINTS = 256
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [8:0]                cfg_point_count,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_action,
  input  logic [7:0]                in_point_index,
  input  logic signed [COORD_W-1:0] in_coord_x,
  input  logic signed [COORD_W-1:0] in_coord_y,
  input  logic signed [COORD_W-1:0] in_coord_z,
  input  logic [T_W-1:0]            in_param_t,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [COORD_W-1:0] out_result_x,
  output logic signed [COORD_W-1:0] out_result_y,
  output logic signed [COORD_W-1:0] out_result_z,
  output logic [1:0]                out_status
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int PW = 3 * COORD_W;
  localparam logic signed [ACC_W-1:0] RND = ACC_W'(T_ONE);
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32'sh7FFFFFFF);
  localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(64'sh80000000);

  crse_state_t state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [8:0]    pc_r;
  logic [1:0]    act_r, act_nxt;
  logic [AW-1:0] seg_r, seg_nxt;
  logic [T_W-1:0] t_r, t_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [2:0]    step_r, step_nxt;
  logic [PW-1:0] p0_r, p0_nxt, pl_r, pl_nxt, p1_r, p1_nxt, p2_r, p2_nxt;
  logic [PW-1:0] pa_r, pa_nxt, pb_r, pb_nxt;
  logic [T_W:0]  t2_r, t2_nxt, t3_r, t3_nxt;
  logic signed [MUL_B_W-1:0] w00_r, w00_nxt, w01_r, w01_nxt;
  logic signed [MUL_B_W-1:0] w10_r, w10_nxt, w11_r, w11_nxt;
  logic [1:0]    term_r, term_nxt, axis_r, axis_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic [PW-1:0] res_r, res_nxt;
  logic [1:0]    rstat_r, rstat_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [PW-1:0] out_res_r, out_res_nxt;
  logic [1:0]    out_status_r, out_status_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [PW-1:0] ram_wdata, ram_rdata;
  crse_mul_req_t mul_req;
  logic signed [PROD_W-1:0] mul_prod;

  logic          accept, closed, in_idx_ok;
  logic [T_W-1:0] t_in;
  logic [CW-1:0] n_in;
  logic signed [COORD_W-1:0] c1, c2, ca, cb;
  logic signed [ACC_W-1:0] acc_sum, rnd;
  logic signed [COORD_W-1:0] sat;
  logic signed [MUL_B_W+1:0] ts, t2s, t3s, h00, h01;

  crse_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata_r(ram_rdata)
  );

  crse_mul u_mul (.clk(clk), .req(mul_req), .prod_r(mul_prod));

  assign in_stall     = (state_r != S_IDLE);
  assign accept       = in_valid && !in_stall;
  assign out_valid    = out_valid_r;
  assign out_result_x = out_res_r[0*COORD_W +: COORD_W];
  assign out_result_y = out_res_r[1*COORD_W +: COORD_W];
  assign out_result_z = out_res_r[2*COORD_W +: COORD_W];
  assign out_status   = out_status_r;

  // clamp t and point count on the way in
  assign t_in      = (in_param_t > T_ONE) ? T_ONE : in_param_t;
  assign n_in      = (32'(pc_r) > MAX_POINTS) ? CW'(MAX_POINTS) : CW'(pc_r);
  assign in_idx_ok = (32'(in_point_index) < MAX_POINTS);
  assign closed    = (p0_r == pl_r);

  // per-axis operands
  assign c1 = p1_r[32'(axis_r) * COORD_W +: COORD_W];
  assign c2 = p2_r[32'(axis_r) * COORD_W +: COORD_W];
  assign ca = pa_r[32'(axis_r) * COORD_W +: COORD_W];
  assign cb = pb_r[32'(axis_r) * COORD_W +: COORD_W];

  // round and saturate the finished sum
  assign acc_sum = acc_r + ACC_W'(mul_prod);
  assign rnd     = (acc_sum + RND) >>> (FRAC_BITS + 1);
  assign sat     = (rnd > SAT_HI) ? COORD_W'(SAT_HI) :
                   (rnd < SAT_LO) ? COORD_W'(SAT_LO) : COORD_W'(rnd);

  // Hermite weights
  assign ts  = (MUL_B_W+2)'(t_r);
  assign t2s = (MUL_B_W+2)'(t2_r);
  assign t3s = (MUL_B_W+2)'(t3_r);
  assign h00 = (MUL_B_W+2)'(2 * t3s - 3 * t2s + (MUL_B_W+2)'(T_ONE));
  assign h01 = (MUL_B_W+2)'(3 * t2s - 2 * t3s);

  // point count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0;
    end else if (cfg_we) begin
      pc_r <= cfg_point_count;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    act_r  <= act_nxt;   seg_r  <= seg_nxt;   t_r    <= t_nxt;
    n_r    <= n_nxt;     step_r <= step_nxt;
    p0_r   <= p0_nxt;    pl_r   <= pl_nxt;    p1_r   <= p1_nxt;
    p2_r   <= p2_nxt;    pa_r   <= pa_nxt;    pb_r   <= pb_nxt;
    t2_r   <= t2_nxt;    t3_r   <= t3_nxt;
    w00_r  <= w00_nxt;   w01_r  <= w01_nxt;   w10_r  <= w10_nxt;
    w11_r  <= w11_nxt;   term_r <= term_nxt;  axis_r <= axis_nxt;
    acc_r  <= acc_nxt;   res_r  <= res_nxt;   rstat_r <= rstat_nxt;
    out_res_r <= out_res_nxt;  out_status_r <= out_status_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;   clr_cnt_nxt = clr_cnt_r;
    act_nxt = act_r;   seg_nxt = seg_r;   t_nxt = t_r;   n_nxt = n_r;
    step_nxt = step_r;
    p0_nxt = p0_r;  pl_nxt = pl_r;  p1_nxt = p1_r;  p2_nxt = p2_r;
    pa_nxt = pa_r;  pb_nxt = pb_r;  t2_nxt = t2_r;  t3_nxt = t3_r;
    w00_nxt = w00_r;  w01_nxt = w01_r;  w10_nxt = w10_r;  w11_nxt = w11_r;
    term_nxt = term_r;  axis_nxt = axis_r;  acc_nxt = acc_r;
    res_nxt = res_r;  rstat_nxt = rstat_r;
    out_res_nxt = out_res_r;  out_status_nxt = out_status_r;
    out_valid_nxt = out_valid_r && out_stall;
    ram_we = 1'b0;
    ram_waddr = AW'(in_point_index);
    ram_wdata = {in_coord_z, in_coord_y, in_coord_x};
    ram_raddr = seg_r;
    mul_req.a = '0;
    mul_req.b = '0;

    unique case (state_r)
      // zero the store after reset
      S_CLR: begin
        ram_we = 1'b1;
        ram_waddr = clr_cnt_r;
        ram_wdata = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == AW'(MAX_POINTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      // take a request and sort out the cases that need no curve math
      S_IDLE: begin
        if (accept) begin
          act_nxt = in_action;
          t_nxt = t_in;
          n_nxt = n_in;
          seg_nxt = AW'(in_point_index);
          res_nxt = '0;
          state_nxt = S_FIN;
          unique case (in_action)
            ACT_WRITE: begin
              ram_we = in_idx_ok;
              rstat_nxt = in_idx_ok ? ST_WRITE : ST_RANGE;
            end
            ACT_NONE: rstat_nxt = ST_RANGE;
            ACT_GLOBAL: begin
              if (n_in == '0) begin
                rstat_nxt = ST_EMPTY;
              end else begin
                state_nxt = S_POS;
              end
            end
            ACT_SEGMENT: begin
              if (n_in == '0) begin
                rstat_nxt = ST_EMPTY;
              end else if (32'(in_point_index) >= 32'(n_in)) begin
                rstat_nxt = ST_RANGE;
              end else begin
                state_nxt = S_CHECK;
              end
            end
          endcase
        end
      end
      // split global t into segment and local t
      S_POS: begin
        mul_req.a = MUL_A_W'(n_r - CW'(1));
        mul_req.b = MUL_B_W'(t_r);
        state_nxt = S_POS_W;
      end
      S_POS_W: begin
        seg_nxt = mul_prod[FRAC_BITS +: AW];
        t_nxt = {1'b0, mul_prod[FRAC_BITS-1:0]};
        state_nxt = S_CHECK;
      end
      // end points return a stored point directly
      S_CHECK: begin
        rstat_nxt = ST_EVAL;
        if (CW'(seg_r) + CW'(1) == n_r || t_r == '0) begin
          state_nxt = S_PICK;
        end else if (t_r == T_ONE) begin
          seg_nxt = seg_r + 1'b1;
          state_nxt = S_PICK;
        end else begin
          step_nxt = '0;
          state_nxt = S_READ;
        end
      end
      S_PICK: state_nxt = S_PICK_W;
      S_PICK_W: begin
        res_nxt = ram_rdata;
        state_nxt = S_FIN;
      end
      // fetch ends, segment points and tangent neighbors
      S_READ: begin
        step_nxt = step_r + 1'b1;
        priority case (step_r)
          3'd0: ram_raddr = '0;
          3'd1: ram_raddr = AW'(n_r - CW'(1));
          3'd2: ram_raddr = seg_r;
          3'd3: ram_raddr = seg_r + 1'b1;
          3'd4: begin
            if (seg_r != '0) begin
              ram_raddr = seg_r - 1'b1;
            end else begin
              ram_raddr = closed ? AW'(n_r - CW'(2)) : '0;
            end
          end
          default: begin
            if (CW'(seg_r) + CW'(2) != n_r) begin
              ram_raddr = seg_r + AW'(2);
            end else begin
              ram_raddr = closed ? AW'(1) : seg_r + 1'b1;
            end
          end
        endcase
        priority case (step_r)
          3'd1: p0_nxt = ram_rdata;
          3'd2: pl_nxt = ram_rdata;
          3'd3: p1_nxt = ram_rdata;
          3'd4: p2_nxt = ram_rdata;
          3'd5: pa_nxt = ram_rdata;
          3'd6: begin
            pb_nxt = ram_rdata;
            state_nxt = S_T2;
          end
          default: ;
        endcase
      end
      // t^2 and t^3, rounded half up
      S_T2: begin
        mul_req.a = MUL_A_W'(t_r);
        mul_req.b = MUL_B_W'(t_r);
        state_nxt = S_T2_W;
      end
      S_T2_W: begin
        t2_nxt = (T_W+1)'((mul_prod + PROD_W'(T_ONE >> 1)) >>> FRAC_BITS);
        state_nxt = S_T3;
      end
      S_T3: begin
        mul_req.a = MUL_A_W'(t2_r);
        mul_req.b = MUL_B_W'(t_r);
        state_nxt = S_T3_W;
      end
      S_T3_W: begin
        t3_nxt = (T_W+1)'((mul_prod + PROD_W'(T_ONE >> 1)) >>> FRAC_BITS);
        state_nxt = S_WGT;
      end
      S_WGT: begin
        w00_nxt = MUL_B_W'(2 * h00);
        w01_nxt = MUL_B_W'(2 * h01);
        w10_nxt = MUL_B_W'(t3s - 2 * t2s + ts);
        w11_nxt = MUL_B_W'(t3s - t2s);
        acc_nxt = '0;
        term_nxt = '0;
        axis_nxt = '0;
        state_nxt = S_MUL;
      end
      // one weighted term per pass
      S_MUL: begin
        unique case (term_r)
          2'd0: begin
            mul_req.a = MUL_A_W'(c1);
            mul_req.b = w00_r;
          end
          2'd1: begin
            mul_req.a = MUL_A_W'(c2);
            mul_req.b = w01_r;
          end
          2'd2: begin
            mul_req.a = MUL_A_W'(c2) - MUL_A_W'(ca);
            mul_req.b = w10_r;
          end
          default: begin
            mul_req.a = MUL_A_W'(cb) - MUL_A_W'(c1);
            mul_req.b = w11_r;
          end
        endcase
        state_nxt = S_ACC;
      end
      S_ACC: begin
        acc_nxt = acc_sum;
        term_nxt = term_r + 1'b1;
        state_nxt = S_MUL;
        if (term_r == 2'd3) begin
          res_nxt[32'(axis_r) * COORD_W +: COORD_W] = sat;
          acc_nxt = '0;
          axis_nxt = axis_r + 1'b1;
          if (axis_r == 2'd2) begin
            state_nxt = S_FIN;
          end
        end
      end
      // hand the result to the output register once it is free
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_res_nxt = res_r;
          out_status_nxt = rstat_r;
          out_valid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

endmodule

// File: src/crse_checker.sv
// Port-level checker for the spline evaluator, bound to the top level.
// Depends on crse_pkg and the shared assertion macros.
`include "catmull_rom_spline_evaluator_defines.svh"

module crse_port_checker
  import crse_pkg::*;
(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic signed [COORD_W-1:0] out_result_x,
  input logic signed [COORD_W-1:0] out_result_y,
  input logic signed [COORD_W-1:0] out_result_z,
  input logic [1:0]                out_status
);

  logic not_eval;
  logic res_zero;

  assign not_eval = out_valid && (out_status != ST_EVAL);
  assign res_zero = (out_result_x == '0) && (out_result_y == '0) && (out_result_z == '0);

  // a result that is not an evaluation carries zero coordinates
  `CRSE_ASSERT_IMP(a_zero_res, not_eval, res_zero, "non-evaluation result not zero")
  // one request at a time: busy right after taking one
  `CRSE_ASSERT_NXT(a_busy_after_req, in_valid && !in_stall, in_stall, "request taken while busy")
  // clearing pass blocks requests after reset
  `CRSE_ASSERT_NXT_RST(a_clear_after_rst, !rst_n, in_stall, "request taken during clearing")
  // a stalled result stays offered
  `CRSE_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid, "stalled result dropped")

endmodule

bind catmull_rom_spline_evaluator crse_port_checker u_crse_checker (.*);

// File: dv/crse_checker.sv
`timescale 1ns / 1ps
// Result checker for the spline evaluator: models the point store and curve math.
// Depends on crse_pkg; instantiated by tb_top beside the block.
module crse_checker
  import crse_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [8:0]                cfg_point_count,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [1:0]                in_action,
  input  logic [7:0]                in_point_index,
  input  logic signed [COORD_W-1:0] in_coord_x,
  input  logic signed [COORD_W-1:0] in_coord_y,
  input  logic signed [COORD_W-1:0] in_coord_z,
  input  logic [T_W-1:0]            in_param_t,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic signed [COORD_W-1:0] out_result_x,
  input  logic signed [COORD_W-1:0] out_result_y,
  input  logic signed [COORD_W-1:0] out_result_z,
  input  logic [1:0]                out_status,
  output int                        fail_count,
  output int                        pending,
  output int                        eval_seen
);

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [1:0]  status;
  } curve_result_t;

  logic [31:0] pts [3][256];
  logic [8:0]  npts;
  curve_result_t curve_q[$];

  assign pending = curve_q.size();

  // signed coordinate of point i on one axis
  function automatic longint pc(int ax, int i);
    return longint'($signed(pts[ax][i]));
  endfunction

  // doubled tangent at point i
  function automatic longint tangent2(int ax, int i, int n, bit closed);
    if (i == 0 || (i == n - 1 && closed)) begin
      if (closed) return pc(ax, 1) - pc(ax, n - 2);
      return pc(ax, 1) - pc(ax, 0);
    end
    if (i == n - 1)
      return pc(ax, n - 1) - pc(ax, n - 2);
    return pc(ax, i + 1) - pc(ax, i - 1);
  endfunction

  function automatic logic [31:0] hermite(int ax, int seg, int n, bit closed, longint t);
    longint t2, t3, h00, h01, h10, h11, acc, r;
    t2 = (t * t + 32768) >>> 16;
    t3 = (t2 * t + 32768) >>> 16;
    h00 = 2 * t3 - 3 * t2 + 65536;
    h01 = 3 * t2 - 2 * t3;
    h10 = t3 - 2 * t2 + t;
    h11 = t3 - t2;
    acc = 2 * (h00 * pc(ax, seg) + h01 * pc(ax, seg + 1))
        + h10 * tangent2(ax, seg, n, closed) + h11 * tangent2(ax, seg + 1, n, closed);
    r = (acc + 65536) >>> 17;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  function automatic curve_result_t predict_curve(logic [1:0] act, int idx, longint t);
    curve_result_t res;
    int n, seg, pick;
    longint pos;
    bit closed;
    res = '0;
    n = (npts > 256) ? 256 : npts;
    if (t > 65536) t = 65536;
    if (act == ACT_WRITE) begin
      pts[0][idx] = in_coord_x;
      pts[1][idx] = in_coord_y;
      pts[2][idx] = in_coord_z;
      res.status = ST_WRITE;
      return res;
    end
    if (act == ACT_NONE) begin
      res.status = ST_RANGE;
      return res;
    end
    if (n == 0) begin
      res.status = ST_EMPTY;
      return res;
    end
    if (act == ACT_GLOBAL) begin
      pos = t * (n - 1);
      seg = int'(pos >>> 16);
      t = pos & 65535;
    end else begin
      if (idx >= n) begin
        res.status = ST_RANGE;
        return res;
      end
      seg = idx;
    end
    res.status = ST_EVAL;
    if (seg + 1 == n || t == 0 || t == 65536) begin
      pick = (seg + 1 == n || t == 0) ? seg : seg + 1;
      res.x = pts[0][pick];
      res.y = pts[1][pick];
      res.z = pts[2][pick];
      return res;
    end
    closed = pts[0][0] == pts[0][n-1] && pts[1][0] == pts[1][n-1]
          && pts[2][0] == pts[2][n-1];
    res.x = hermite(0, seg, n, closed, t);
    res.y = hermite(1, seg, n, closed, t);
    res.z = hermite(2, seg, n, closed, t);
    return res;
  endfunction

  // predict on accepted requests, compare on accepted results
  always @(posedge clk) begin
    curve_result_t want;
    if (!rst_n) begin
      for (int a = 0; a < 3; a++)
        for (int i = 0; i < 256; i++) pts[a][i] = '0;
      npts = '0;
      curve_q.delete();
      fail_count = 0;
      eval_seen = 0;
    end else begin
      if (cfg_we) npts = cfg_point_count;
      if (in_valid && !in_stall)
        curve_q.insert(curve_q.size(),
                       predict_curve(in_action, in_point_index, longint'(in_param_t)));
      if (out_valid && !out_stall) begin
        if (out_status == ST_EVAL) eval_seen++;
        if (curve_q.size() == 0) begin
          $display("%0t: unexpected result x=%h y=%h z=%h status=%0d", $time,
                   out_result_x, out_result_y, out_result_z, out_status);
          fail_count++;
        end else begin
          want = curve_q.pop_front();
          if (want.x != out_result_x || want.y != out_result_y ||
              want.z != out_result_z || want.status != out_status) begin
            $display("%0t: mismatch expected x=%h y=%h z=%h st=%0d",
                     $time, want.x, want.y, want.z, want.status);
            $display("%0t:          actual   x=%h y=%h z=%h st=%0d",
                     $time, out_result_x, out_result_y, out_result_z, out_status);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the spline evaluator: writes points, sweeps counts, evaluates.
// Depends on crse_pkg, catmull_rom_spline_evaluator and crse_checker.
module tb_top;
  import crse_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [8:0] cfg_point_count = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_action = '0;
  logic [7:0] in_point_index = '0;
  logic signed [31:0] in_coord_x = '0, in_coord_y = '0, in_coord_z = '0;
  logic [T_W-1:0] in_param_t = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_result_x, out_result_y, out_result_z;
  logic [1:0] out_status;
  int fail_count, pending, eval_seen;
  int idle_cycles = 0;
  int sent = 0;
  bit sending = 1'b0;
  int stall_mode = 0;

  always #1 clk = ~clk;

  catmull_rom_spline_evaluator uut (.*);

  crse_checker chk (.*);

  // receiver stall pattern: change mode now and then
  always @(posedge clk) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= ($urandom_range(0, 9) != 0);
    endcase
  end

  // watchdog: cycles without any accepted request or result
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !sending) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return $urandom;
      default: return $signed($urandom_range(0, 2000000)) - 1000000;
    endcase
  endfunction

  function automatic logic [16:0] pick_t();
    case ($urandom_range(0, 7))
      0: return 17'd0;
      1: return 17'd65536;
      2: return 17'h1ffff;
      3: return 17'($urandom_range(65537, 131071));
      default: return 17'($urandom_range(1, 65535));
    endcase
  endfunction

  // send one request; hold it until taken, with random gaps between bursts
  task automatic send_req(logic [1:0] act, logic [7:0] idx, logic [31:0] x, logic [31:0] y,
                          logic [31:0] z, logic [16:0] t);
    in_valid <= 1'b1;
    in_action <= act;
    in_point_index <= idx;
    in_coord_x <= x;
    in_coord_y <= y;
    in_coord_z <= z;
    in_param_t <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
    if ($urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_count(logic [8:0] n);
    drain();
    cfg_we <= 1'b1;
    cfg_point_count <= n;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int n;
    logic [31:0] c;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    sending = 1'b1;
    // directed: empty store, writes at extremes, each action, closed loop
    send_req(ACT_GLOBAL, 8'd0, 0, 0, 0, 17'd30000);
    send_req(ACT_NONE, 8'd5, 0, 0, 0, 17'd0);
    send_req(ACT_WRITE, 8'd0, 32'h7fffffff, 32'h80000000, 32'h0, 17'd0);
    send_req(ACT_WRITE, 8'd255, 32'h80000000, 32'h7fffffff, 32'hffffffff, 17'h1ffff);
    send_req(ACT_WRITE, 8'd1, 32'h80000000, 32'h7fffffff, 32'h12345678, 17'd0);
    send_req(ACT_WRITE, 8'd2, 32'h00010000, 32'hfffe0000, 32'h0, 17'd0);
    send_req(ACT_WRITE, 8'd3, 32'h7fffffff, 32'h80000000, 32'h0, 17'd0);
    set_count(9'd1);
    send_req(ACT_GLOBAL, 8'd0, 0, 0, 0, 17'd40000);
    send_req(ACT_SEGMENT, 8'd1, 0, 0, 0, 17'd100);
    set_count(9'd4);
    send_req(ACT_SEGMENT, 8'd0, 0, 0, 0, 17'd32768);
    send_req(ACT_SEGMENT, 8'd1, 0, 0, 0, 17'd1);
    send_req(ACT_SEGMENT, 8'd2, 0, 0, 0, 17'd65535);
    send_req(ACT_SEGMENT, 8'd3, 0, 0, 0, 17'd20000);
    send_req(ACT_SEGMENT, 8'd1, 0, 0, 0, 17'd0);
    send_req(ACT_SEGMENT, 8'd1, 0, 0, 0, 17'd65536);
    send_req(ACT_GLOBAL, 8'd0, 0, 0, 0, 17'h1ffff);
    send_req(ACT_GLOBAL, 8'd0, 0, 0, 0, 17'd43690);
    send_req(ACT_SEGMENT, 8'd4, 0, 0, 0, 17'd10);
    set_count(9'd256);
    send_req(ACT_GLOBAL, 8'd0, 0, 0, 0, 17'd65535);
    send_req(ACT_SEGMENT, 8'd255, 0, 0, 0, 17'd500);
    set_count(9'd511);
    send_req(ACT_GLOBAL, 8'd0, 0, 0, 0, 17'd12345);
    // random phases: refill points, pick a count, evaluate
    while (sent < 1410) begin
      case ($urandom_range(0, 5))
        0: n = $urandom_range(257, 511);
        1: n = $urandom_range(0, 3);
        2: n = 256;
        default: n = $urandom_range(4, 24);
      endcase
      set_count(n[8:0]);
      for (int i = 0; i < 40; i++) begin
        int r;
        int top;
        r = $urandom_range(0, 99);
        top = (n > 255) ? 255 : ((n < 2) ? 30 : n);
        if (r < 25) begin
          c = pick_coord();
          send_req(ACT_WRITE, 8'($urandom_range(0, top)), c, pick_coord(), pick_coord(),
                   pick_t());
        end else if (r < 30) begin
          c = pick_coord();
          send_req(ACT_WRITE, 8'((n > 1 && n < 257) ? n - 1 : 0), 32'h7fffffff & c, c, c,
                   17'd0);
        end else if (r < 35) begin
          send_req(ACT_NONE, 8'($urandom), $urandom, $urandom, $urandom, pick_t());
        end else if (r < 65) begin
          send_req(ACT_GLOBAL, 8'($urandom), $urandom, $urandom, $urandom, pick_t());
        end else begin
          send_req(ACT_SEGMENT,
                   8'(($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, top)),
                   $urandom, $urandom, $urandom, pick_t());
        end
      end
    end
    drain();
    sending = 1'b0;
    $display("Sent %0d requests over varied point counts; %0d curve evaluations checked.",
             sent, eval_seen);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
